FILE: sv/sktab_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table package
// Command and status codes, beat field widths and the control bundle that
// steers the row of table cells.
// ----------------------------------------------------------------------------
package sktab_pkg;

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

FILE: sv/sktab_in_if.sv
// ----------------------------------------------------------------------------
// Sorted key table command channel
// Valid/ready channel carrying one table operation per beat.
// ----------------------------------------------------------------------------
interface sktab_in_if;

    logic                                  valid;
    logic                                  ready;
    logic [sktab_pkg::CMD_W-1:0]           command;
    logic signed [sktab_pkg::KEY_W-1:0]    key;
    logic [sktab_pkg::PAYLOAD_W-1:0]       payload;

    modport source (output valid, output command, output key, output payload, input ready);
    modport sink   (input valid, input command, input key, input payload, output ready);

endinterface

FILE: sv/sktab_out_if.sv
// ----------------------------------------------------------------------------
// Sorted key table result channel
// Valid/ready channel carrying one operation result per beat.
// ----------------------------------------------------------------------------
interface sktab_out_if;

    logic                              valid;
    logic                              ready;
    logic [sktab_pkg::STATUS_W-1:0]    status;
    logic [sktab_pkg::PAYLOAD_W-1:0]   found_payload;
    logic [sktab_pkg::COUNT_W-1:0]     entry_count;
    logic                              table_empty;

    modport source (output valid, output status, output found_payload,
                    output entry_count, output table_empty, input ready);
    modport sink   (input valid, input status, input found_payload,
                    input entry_count, input table_empty, output ready);

endinterface

FILE: sv/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key table unit
// Up to CAPACITY entries kept in ascending signed key order in a row of cells.
// ----------------------------------------------------------------------------
// Each command runs through a compare step and an apply step after its accepted
// beat: in the compare step every cell compares its key with the command key in
// parallel, in the apply step the row shifts one place to open or close a slot
// and the result is registered. A new command is accepted in the same cycle the
// previous one finishes, so commands follow each other back to back whatever the
// fill level, as long as the result channel keeps up. A pending result beat
// stalls the finishing step only. Inserts store the low PAYLOAD_BITS bits of
// the payload; entry_count reports the low 7 bits of the fill level.
module sorted_key_table_unit #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sktab_in_if.sink    i_cmd,
    sktab_out_if.source o_res
);

    import sktab_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APP
    } t_state;

    t_state                  r_state;
    logic [CMD_W-1:0]        r_cmd;
    logic signed [KEY_W-1:0] r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic [STATUS_W-1:0]     n_status;
    logic [PAYLOAD_W-1:0]    r_found;
    logic [PAYLOAD_W-1:0]    n_found;

    t_cell_ctl               w_ctl;
    logic                    w_in_fire;
    logic                    w_app_fire;
    logic                    w_hit;
    logic                    w_full;
    logic [PAYLOAD_BITS-1:0] w_match_pl;

    logic                    w_valid   [CAPACITY];
    logic                    w_lt      [CAPACITY];
    logic                    w_eq      [CAPACITY];
    logic signed [KEY_W-1:0] w_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_payload [CAPACITY];

    assign w_app_fire  = (r_state == S_APP) && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = (r_state == S_IDLE) || w_app_fire;
    assign w_in_fire   = i_cmd.valid && i_cmd.ready;
    assign w_full      = w_valid[CAPACITY-1];

    always_comb begin
        w_hit      = 1'b0;
        w_match_pl = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit      = w_hit | w_eq[i];
            w_match_pl = w_match_pl | (w_eq[i] ? w_payload[i] : '0);
        end
    end

    always_comb begin
        w_ctl.cmp = (r_state == S_CMP);
        w_ctl.ins = w_app_fire && (r_cmd == CMD_INSERT) && !w_hit && !w_full;
        w_ctl.del = w_app_fire && (r_cmd == CMD_DELETE) && w_hit;
    end

    always_comb begin
        n_status = ST_OK;
        n_found  = '0;
        n_count  = r_count;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (w_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (!w_hit) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_SEARCH: begin
                if (!w_hit) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_found = PAYLOAD_W'(w_match_pl);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_lv;
        logic                    w_llt;
        logic signed [KEY_W-1:0] w_lk;
        logic [PAYLOAD_BITS-1:0] w_lp;
        logic                    w_rv;
        logic signed [KEY_W-1:0] w_rk;
        logic [PAYLOAD_BITS-1:0] w_rp;

        if (g == 0) begin : g_head
            assign w_lv  = 1'b1;
            assign w_llt = 1'b1;
            assign w_lk  = '0;
            assign w_lp  = '0;
        end else begin : g_left
            assign w_lv  = w_valid[g-1];
            assign w_llt = w_lt[g-1];
            assign w_lk  = w_key[g-1];
            assign w_lp  = w_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rk = '0;
            assign w_rp = '0;
        end else begin : g_right
            assign w_rv = w_valid[g+1];
            assign w_rk = w_key[g+1];
            assign w_rp = w_payload[g+1];
        end

        sktab_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_key           (r_key),
            .i_payload       (r_payload),
            .i_left_valid    (w_lv),
            .i_left_lt       (w_llt),
            .i_left_key      (w_lk),
            .i_left_payload  (w_lp),
            .i_right_valid   (w_rv),
            .i_right_key     (w_rk),
            .i_right_payload (w_rp),
            .o_valid         (w_valid[g]),
            .o_lt            (w_lt[g]),
            .o_eq            (w_eq[g]),
            .o_key           (w_key[g]),
            .o_payload       (w_payload[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_app_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APP;
                end
                S_APP: begin
                    if (w_app_fire) begin
                        r_status    <= n_status;
                        r_found     <= n_found;
                        r_count     <= n_count;
                        r_state     <= w_in_fire ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_in_fire) begin
                r_cmd     <= i_cmd.command;
                r_key     <= i_cmd.key;
                r_payload <= i_cmd.payload[PAYLOAD_BITS-1:0];
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.found_payload = r_found;
    assign o_res.entry_count   = COUNT_W'(r_count);
    assign o_res.table_empty   = (r_count == '0);

endmodule

FILE: sv/sktab_cell.sv
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry; compares it with the operation key and shifts entries
// right on insert or left on delete.
// ----------------------------------------------------------------------------
module sktab_cell #(
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sktab_pkg::t_cell_ctl                i_ctl,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_key,
    input  logic [PAYLOAD_BITS-1:0]             i_payload,
    input  logic                                i_left_valid,
    input  logic                                i_left_lt,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_left_key,
    input  logic [PAYLOAD_BITS-1:0]             i_left_payload,
    input  logic                                i_right_valid,
    input  logic signed [sktab_pkg::KEY_W-1:0]  i_right_key,
    input  logic [PAYLOAD_BITS-1:0]             i_right_payload,
    output logic                                o_valid,
    output logic                                o_lt,
    output logic                                o_eq,
    output logic signed [sktab_pkg::KEY_W-1:0]  o_key,
    output logic [PAYLOAD_BITS-1:0]             o_payload
);

    import sktab_pkg::*;

    logic                    r_valid;
    logic                    r_lt;
    logic                    r_eq;
    logic signed [KEY_W-1:0] r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_lt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_lt <= r_valid && (r_key < i_key);
                r_eq <= r_valid && (r_key == i_key);
            end
            if (i_ctl.ins && !r_lt) begin
                if (i_left_lt) begin
                    r_valid   <= 1'b1;
                    r_key     <= i_key;
                    r_payload <= i_payload;
                end else begin
                    r_valid   <= i_left_valid;
                    r_key     <= i_left_key;
                    r_payload <= i_left_payload;
                end
            end else if (i_ctl.del && !r_lt) begin
                r_valid   <= i_right_valid;
                r_key     <= i_right_key;
                r_payload <= i_right_payload;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_lt      = r_lt;
    assign o_eq      = r_eq;
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule
